FILE: sv/netstring_deframer_defines.svh
`ifndef NETSTRING_DEFRAMER_DEFINES_SVH
`define NETSTRING_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define NSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/nsd_pkg.sv
`default_nettype none

package nsd_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam logic [31:0] MAX_LENGTH_RST  = 32'd65536;

    // register indexes (paddr[2])
    localparam logic REG_MAX_LENGTH = 1'b0;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ERR_BAD_CHAR     = 3'd0;
    localparam logic [2:0] ERR_LEADING_ZERO = 3'd1;
    localparam logic [2:0] ERR_NO_COMMA     = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG     = 3'd3;
    localparam logic [2:0] ERR_EMPTY_LENGTH = 3'd4;
    localparam logic [2:0] ERR_NONE         = 3'd0;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_LEN   = 3'b001,
        PH_DATA  = 3'b010,
        PH_COMMA = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_ZERO = 2'd1,
        DS_NZ   = 2'd2
    } t_digits;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] code;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/nsd_regs.sv
`default_nettype none

module nsd_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [31:0] o_max_length
);

    logic [31:0] r_max_length;
    logic        w_hit;

    assign w_hit = (paddr[2] == nsd_pkg::REG_MAX_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= nsd_pkg::MAX_LENGTH_RST;
        end else if (psel && penable && pwrite && w_hit) begin
            r_max_length <= pwdata;
        end
    end

    assign prdata       = w_hit ? r_max_length : 32'd0;
    assign pready       = 1'b1;
    assign o_max_length = r_max_length;

endmodule

`default_nettype wire

FILE: sv/nsd_core.sv
`default_nettype none

module nsd_core #(
    parameter int unsigned LENGTH_BITS = nsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic [31:0] i_max_length,
    output logic             o_valid,
    output nsd_pkg::t_result o_result
);

    // wide enough for count*10+9 and for the 32-bit limit
    localparam int unsigned SumW = (LENGTH_BITS > 32) ? LENGTH_BITS + 4 : 36;

    nsd_pkg::t_phase  r_phase, n_phase;
    nsd_pkg::t_digits r_digits, n_digits;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LENGTH_BITS-1:0] w_dec;
    logic [SumW-1:0]        w_sum;
    logic                   w_too_big;
    logic                   w_is_digit;

    assign w_dec      = r_count - LENGTH_BITS'(1);
    assign w_is_digit = (i_byte >= nsd_pkg::CH_ZERO) && (i_byte <= nsd_pkg::CH_NINE);
    // count*10 + d via shift-add; digit value is the low nibble of the ASCII code
    assign w_sum      = (SumW'(r_count) << 3) + (SumW'(r_count) << 1) + SumW'(i_byte[3:0]);
    assign w_too_big  = (w_sum > SumW'(i_max_length)) || (|w_sum[SumW-1:LENGTH_BITS]);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_digits = r_digits;
        o_valid  = 1'b0;
        o_result = '{kind: nsd_pkg::KIND_DATA, data: 8'd0, last: 1'b0,
                     code: nsd_pkg::ERR_NONE};
        if (i_valid) begin
            unique case (r_phase)
                nsd_pkg::PH_DATA: begin
                    n_count       = w_dec;
                    if (w_dec == '0) n_phase = nsd_pkg::PH_COMMA;
                    o_valid       = 1'b1;
                    o_result.data = i_byte;
                    o_result.last = (w_dec == '0);
                end
                nsd_pkg::PH_COMMA: begin
                    n_phase  = nsd_pkg::PH_LEN;
                    n_count  = '0;
                    n_digits = nsd_pkg::DS_NONE;
                    o_valid  = 1'b1;
                    if (i_byte == nsd_pkg::CH_COMMA) begin
                        o_result.kind = nsd_pkg::KIND_DONE;
                    end else begin
                        o_result.kind = nsd_pkg::KIND_ERR;
                        o_result.code = nsd_pkg::ERR_NO_COMMA;
                    end
                end
                default: begin
                    if (i_byte == nsd_pkg::CH_COLON) begin
                        if (r_digits == nsd_pkg::DS_NONE) begin
                            o_valid       = 1'b1;
                            o_result.kind = nsd_pkg::KIND_ERR;
                            o_result.code = nsd_pkg::ERR_EMPTY_LENGTH;
                            n_phase       = nsd_pkg::PH_LEN;
                            n_count       = '0;
                        end else begin
                            n_digits = nsd_pkg::DS_NONE;
                            n_phase  = (r_count == '0) ? nsd_pkg::PH_COMMA : nsd_pkg::PH_DATA;
                        end
                    end else if (!w_is_digit || r_digits == nsd_pkg::DS_ZERO
                                 || (r_digits == nsd_pkg::DS_NZ || i_byte != nsd_pkg::CH_ZERO)
                                    && w_too_big) begin
                        o_valid       = 1'b1;
                        o_result.kind = nsd_pkg::KIND_ERR;
                        if (!w_is_digit) begin
                            o_result.code = nsd_pkg::ERR_BAD_CHAR;
                        end else if (r_digits == nsd_pkg::DS_ZERO) begin
                            o_result.code = nsd_pkg::ERR_LEADING_ZERO;
                        end else begin
                            o_result.code = nsd_pkg::ERR_TOO_LONG;
                        end
                        n_phase  = nsd_pkg::PH_LEN;
                        n_count  = '0;
                        n_digits = nsd_pkg::DS_NONE;
                    end else if (r_digits == nsd_pkg::DS_NONE && i_byte == nsd_pkg::CH_ZERO) begin
                        n_digits = nsd_pkg::DS_ZERO;
                        n_phase  = nsd_pkg::PH_LEN;
                    end else begin
                        n_count  = w_sum[LENGTH_BITS-1:0];
                        n_digits = nsd_pkg::DS_NZ;
                        n_phase  = nsd_pkg::PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nsd_pkg::PH_LEN;
            r_count  <= '0;
            r_digits <= nsd_pkg::DS_NONE;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_digits <= n_digits;
        end
    end

endmodule

`default_nettype wire

FILE: sv/nsd_obuf.sv
`default_nettype none

module nsd_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire nsd_pkg::t_result i_result,
    output logic                  o_ready,
    output logic                  o_valid,
    output nsd_pkg::t_result      o_result,
    input  wire logic             i_pop_ready
);

    // two-entry output buffer; slot 0 is the head
    nsd_pkg::t_result r_slot [2];
    logic [1:0]       r_cnt;
    logic             w_pop;

    assign o_valid  = (r_cnt != 2'd0);
    assign o_ready  = (r_cnt != 2'd2);
    assign o_result = r_slot[0];
    assign w_pop    = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({i_push, w_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_slot[0] <= i_result;
                end else begin
                    r_slot[1] <= i_result;
                end
            end
            2'b01: begin
                r_slot[0] <= r_slot[1];
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_slot[0] <= i_result;
                end else begin
                    r_slot[0] <= r_slot[1];
                    r_slot[1] <= i_result;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/netstring_deframer.sv
// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata[7:0] in_byte
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata data_byte,error_code; tuser kind;
//                                               tlast last_byte
// apb        in   psel/penable/pwrite/pready    max_length at byte address 0
//
// One byte per cycle while the output buffer has room. Each byte updates the
// length/phase state in the cycle it is taken; any result is registered in a
// two-entry output buffer. s_axis_tready drops only while the buffer holds two
// items. Reset is synchronous, active low; max_length resets to 65536.
`default_nettype none

`include "netstring_deframer_defines.svh"

module netstring_deframer #(
    parameter int unsigned LENGTH_BITS = nsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] error_code, rest 0
    output logic      [1:0]  m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,   // last_byte
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [31:0]      w_max_length;
    logic             w_accept;
    logic             w_res_valid;
    nsd_pkg::t_result w_res;
    nsd_pkg::t_result w_head;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    nsd_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (w_max_length)
    );

    nsd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_byte       (s_axis_tdata),
        .i_max_length (w_max_length),
        .o_valid      (w_res_valid),
        .o_result     (w_res)
    );

    nsd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_result    (w_res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_head),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, w_head.code, w_head.data};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    // input stalls only when results are pending
    `NSD_ASSERT_NOW(a_stall_has_pending, !s_axis_tready, m_axis_tvalid, "stall with empty buffer")
    // a byte that yields a result makes m_axis_tvalid high the next cycle
    `NSD_ASSERT_NEXT(a_result_shown, w_res_valid, m_axis_tvalid, "result not buffered")
    // tlast only on payload bytes
    `NSD_ASSERT_NOW(a_last_on_data, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == nsd_pkg::KIND_DATA, "tlast on non-payload item")
    // error code only on error items
    `NSD_ASSERT_NOW(a_code_on_err, m_axis_tvalid && m_axis_tuser != nsd_pkg::KIND_ERR,
        m_axis_tdata[10:8] == 3'd0, "error code on non-error item")

endmodule

`default_nettype wire

FILE: tb/sv/netstring_deframer_tb.sv
`timescale 1ns / 1ps

module netstring_deframer_tb;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        nsd_pkg::t_phase  ph;
        logic [31:0]      count;
        nsd_pkg::t_digits ds;
    } t_deframe_state;

    localparam t_deframe_state FRAME_IDLE = {nsd_pkg::PH_LEN, 32'd0, nsd_pkg::DS_NONE};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;   // [7:0] data_byte, [10:8] error_code, rest 0
    wire  [1:0]  m_axis_tuser;   // [1:0] kind
    wire         m_axis_tlast;
    wire  [31:0] prdata;
    wire         pready;

    // live copy follows accepted items; plan copy follows generated items
    t_deframe_state live = FRAME_IDLE;
    t_deframe_state plan = FRAME_IDLE;
    logic [31:0]    live_lim = nsd_pkg::MAX_LENGTH_RST;
    logic [31:0]    plan_lim = nsd_pkg::MAX_LENGTH_RST;

    logic [7:0]       stream_bytes[$];
    nsd_pkg::t_result awaited_results[$];
    nsd_pkg::t_result got;
    nsd_pkg::t_result head;
    int               pushed = 0;
    int               accepted_bytes = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    // one stretch of the run with no idling on either side
    wire calm = (accepted_bytes >= 400) && (accepted_bytes < 650);

    netstring_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Next deframer state for one byte; returns 1 when the byte yields a result.
    function automatic bit deframe_byte(input t_deframe_state cur, input logic [31:0] lim,
                                        input logic [7:0] b, output t_deframe_state nxt,
                                        output nsd_pkg::t_result res);
        logic [63:0] digit;
        logic [2:0]  code;
        bit          fault;
        bit          emitted;
        nxt = cur;
        fault = 1'b0;
        emitted = 1'b0;
        code = nsd_pkg::ERR_NONE;
        res.kind = nsd_pkg::KIND_DATA;
        res.data = 8'd0;
        res.last = 1'b0;
        res.code = nsd_pkg::ERR_NONE;
        digit = {56'd0, b - nsd_pkg::CH_ZERO};
        case (cur.ph)
            nsd_pkg::PH_DATA: begin
                nxt.count = cur.count - 32'd1;
                res.data = b;
                res.last = (nxt.count == 32'd0);
                if (nxt.count == 32'd0) nxt.ph = nsd_pkg::PH_COMMA;
                emitted = 1'b1;
            end
            nsd_pkg::PH_COMMA: begin
                if (b != nsd_pkg::CH_COMMA) begin
                    fault = 1'b1;
                    code = nsd_pkg::ERR_NO_COMMA;
                end else begin
                    nxt = FRAME_IDLE;
                    res.kind = nsd_pkg::KIND_DONE;
                    emitted = 1'b1;
                end
            end
            default: begin
                if (b == nsd_pkg::CH_COLON) begin
                    if (cur.ds == nsd_pkg::DS_NONE) begin
                        fault = 1'b1;
                        code = nsd_pkg::ERR_EMPTY_LENGTH;
                    end else begin
                        nxt.ds = nsd_pkg::DS_NONE;
                        nxt.ph = (cur.count == 32'd0) ? nsd_pkg::PH_COMMA : nsd_pkg::PH_DATA;
                    end
                end else if (b < nsd_pkg::CH_ZERO || b > nsd_pkg::CH_NINE) begin
                    fault = 1'b1;
                    code = nsd_pkg::ERR_BAD_CHAR;
                end else if (cur.ds == nsd_pkg::DS_ZERO) begin
                    fault = 1'b1;
                    code = nsd_pkg::ERR_LEADING_ZERO;
                end else if (cur.ds == nsd_pkg::DS_NONE && digit == 64'd0) begin
                    nxt.ds = nsd_pkg::DS_ZERO;
                end else if (digit > lim || cur.count > (lim - digit) / 10) begin
                    fault = 1'b1;
                    code = nsd_pkg::ERR_TOO_LONG;
                end else begin
                    nxt.count = cur.count * 32'd10 + digit[31:0];
                    nxt.ds = nsd_pkg::DS_NZ;
                end
            end
        endcase
        if (fault) begin
            nxt = FRAME_IDLE;
            res.kind = nsd_pkg::KIND_ERR;
            res.code = code;
            emitted = 1'b1;
        end
        return emitted;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        nsd_pkg::t_result unused;
        void'(deframe_byte(plan, plan_lim, b, plan, unused));
        stream_bytes.push_back(b);
        pushed++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_number(input logic [63:0] n);
        push_text($sformatf("%0d", n));
    endtask

    // bring the stream back to the start of a length
    task automatic resync();
        while (plan.ph != nsd_pkg::PH_LEN || plan.ds != nsd_pkg::DS_NONE) begin
            if (plan.ph == nsd_pkg::PH_DATA) push_byte(8'($urandom_range(0, 255)));
            else if (plan.ph == nsd_pkg::PH_COMMA) push_byte(nsd_pkg::CH_COMMA);
            else push_byte("x");
        end
    endtask

    task automatic run_random(input int budget);
        int          stop;
        int          pick;
        logic [31:0] len;
        logic [7:0]  b;
        stop = pushed + budget;
        while (pushed < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 76) begin
                if (plan_lim <= 32'd40) len = $urandom_range(0, plan_lim);
                else if ($urandom_range(0, 29) == 0 && plan_lim <= 32'd400) len = plan_lim;
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(41, plan_lim < 32'd200 ? plan_lim : 32'd200);
                else len = $urandom_range(0, 40);
                push_number(len);
                push_byte(nsd_pkg::CH_COLON);
                repeat (len) push_byte(8'($urandom_range(0, 255)));
                b = 8'($urandom_range(0, 255));
                if (b == nsd_pkg::CH_COMMA) b = ~b;
                push_byte(pick < 70 ? nsd_pkg::CH_COMMA : b);
            end else if (pick < 80) begin
                push_byte(nsd_pkg::CH_ZERO);
                push_byte(nsd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick < 83) begin
                push_byte(nsd_pkg::CH_COLON);
            end else if (pick < 88) begin
                push_number({32'd0, plan_lim} + 64'd1 + $urandom_range(0, 9));
            end else if (pick < 93) begin
                push_number($urandom_range(0, 99));
                b = 8'($urandom_range(0, 255));
                if (b >= nsd_pkg::CH_ZERO && b <= nsd_pkg::CH_COLON) b = b ^ 8'h40;
                push_byte(b);
            end else begin
                // raw noise; keep any length it builds short
                repeat ($urandom_range(1, 8)) begin
                    b = 8'($urandom_range(0, 255));
                    if (plan.ph == nsd_pkg::PH_LEN && b >= nsd_pkg::CH_ZERO
                        && b <= nsd_pkg::CH_NINE && plan.count >= 20)
                        b = b ^ 8'h40;
                    push_byte(b);
                end
            end
            resync();
        end
    endtask

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {nsd_pkg::REG_MAX_LENGTH, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        live_lim = value;
        plan_lim = value;
        @(negedge i_clk);
    endtask

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] seen);
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, seen);
        mismatches++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_bytes++;
                if (deframe_byte(live, live_lim, s_axis_tdata, live, got))
                    awaited_results.push_back(got);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (stream_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= stream_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected: kind %0d data %0h last %0b code %0d",
                         $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                         m_axis_tdata[10:8]);
                mismatches++;
            end else begin
                head = awaited_results.pop_front();
                if (m_axis_tuser != head.kind)
                    report("kind", 8'(head.kind), 8'(m_axis_tuser));
                if (m_axis_tdata[7:0] != head.data) report("data", head.data, m_axis_tdata[7:0]);
                if (m_axis_tlast != head.last)
                    report("last", 8'(head.last), 8'(m_axis_tlast));
                if (m_axis_tdata[10:8] != head.code)
                    report("error code", 8'(head.code), 8'(m_axis_tdata[10:8]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL netstring_deframer");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit: empty message, byte extremes, each framing error but too-long
        push_text("0:,");
        push_text("3:");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(nsd_pkg::CH_COMMA);
        push_byte(nsd_pkg::CH_COMMA);
        push_text("00");
        push_byte(nsd_pkg::CH_COLON);
        push_text("1:Ax");
        push_byte(nsd_pkg::CH_ZERO - 8'd1);
        push_byte(nsd_pkg::CH_COLON + 8'd1);
        resync();
        wait_drained();

        write_max_length(32'd0);
        run_random(120);
        wait_drained();

        // one past the full counter range
        write_max_length(32'hFFFF_FFFF);
        push_number(64'd4294967296);
        resync();
        run_random(200);
        wait_drained();

        write_max_length(32'd7);
        run_random(200);
        wait_drained();

        write_max_length(32'd300);
        run_random(300);
        wait_drained();

        write_max_length(nsd_pkg::MAX_LENGTH_RST);
        run_random(280);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("PASS netstring_deframer");
        end else begin
            $display("FAIL netstring_deframer");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/nsd_pkg.sv
sv/nsd_regs.sv
sv/nsd_core.sv
sv/nsd_obuf.sv
sv/netstring_deframer.sv
tb/sv/netstring_deframer_tb.sv
